// ----- src/i2crts_pkg.sv -----
// ----------------------------------------------------------------------------
// i2crts_pkg
// Shared types and codes for the I2C register transfer sequencer: request and
// engine status codes, engine commands, result descriptors.
// ----------------------------------------------------------------------------
package i2crts_pkg;

	// Data bytes per transfer; also the depth of the write buffer
	localparam int MaxLen   = 16;
	localparam int BufAw    = $clog2(MaxLen);
	localparam int LenW     = 5;

	// Request types
	localparam logic [1:0] REQ_LOAD   = 2'd0;
	localparam logic [1:0] REQ_WRITE  = 2'd1;
	localparam logic [1:0] REQ_READ   = 2'd2;
	localparam logic [1:0] REQ_STATUS = 2'd3;

	// Engine status codes; anything above ST_OTHER counts as other
	localparam logic [3:0] ST_START      = 4'd0;
	localparam logic [3:0] ST_RSTART     = 4'd1;
	localparam logic [3:0] ST_ADDRW_ACK  = 4'd2;
	localparam logic [3:0] ST_ADDRW_NACK = 4'd3;
	localparam logic [3:0] ST_TX_ACK     = 4'd4;
	localparam logic [3:0] ST_TX_NACK    = 4'd5;
	localparam logic [3:0] ST_ADDRR_ACK  = 4'd6;
	localparam logic [3:0] ST_ADDRR_NACK = 4'd7;
	localparam logic [3:0] ST_RX_ACK     = 4'd8;
	localparam logic [3:0] ST_RX_NACK    = 4'd9;
	localparam logic [3:0] ST_OTHER      = 4'd10;

	typedef enum logic [1:0] {
		KIND_CMD  = 2'd0,
		KIND_DATA = 2'd1,
		KIND_DONE = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		CMD_START  = 3'd0,
		CMD_SEND   = 3'd1,
		CMD_RXACK  = 3'd2,
		CMD_RXNACK = 3'd3,
		CMD_STOP   = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		DONE_OK     = 2'd0,
		DONE_FAILED = 2'd1,
		DONE_BUSERR = 2'd2
	} done_t;

	// One result item; use_buf marks a send byte taken from the write buffer
	typedef struct packed {
		kind_t      kind;
		cmd_t       cmd;
		logic       use_buf;
		logic [7:0] send_byte;
		logic [7:0] read_byte;
		logic [3:0] read_index;
		done_t      done;
	} res_t;

	// All results of one input item, in order; cnt is 1 to 3
	typedef struct packed {
		res_t [2:0] res;
		logic [1:0] cnt;
	} bundle_t;

	// Write buffer access from the controller
	typedef struct packed {
		logic             we;
		logic [BufAw-1:0] waddr;
		logic [7:0]       wdata;
		logic             re;
		logic [BufAw-1:0] raddr;
	} buf_req_t;

endpackage

// ----- src/i2crts_wbuf.sv -----
// ----------------------------------------------------------------------------
// i2crts_wbuf
// Write data buffer: one write port, one synchronous read port with the read
// data registered.
// ----------------------------------------------------------------------------
module i2crts_wbuf import i2crts_pkg::*; (
	input  logic       clk,
	input  buf_req_t   req,
	output logic [7:0] rdata
);

	logic [7:0] mem [MaxLen];

	// Store loaded bytes
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	// Registered read; hold the data between reads
	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

// ----- src/i2crts_ctrl.sv -----
// ----------------------------------------------------------------------------
// i2crts_ctrl
// Transaction controller: holds the transaction state, decodes each accepted
// item into its result descriptors and keeps them in the stage register.
// ----------------------------------------------------------------------------
module i2crts_ctrl import i2crts_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_write_en,
	input  logic [2:0]      cfg_write_data,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [1:0]      req_type,
	input  logic [7:0]      device_address,
	input  logic [7:0]      register_address,
	input  logic [4:0]      byte_count,
	input  logic [3:0]      load_index,
	input  logic [7:0]      load_byte,
	input  logic [3:0]      engine_status,
	input  logic [7:0]      received_byte,
	input  logic            move,
	output logic            bund_valid_s1,
	output bundle_t         bund_s1,
	output buf_req_t        buf_req
);

	typedef enum logic [3:0] {
		PH_IDLE, PH_START, PH_ADDRW, PH_REG, PH_DATA, PH_RSTART, PH_ADDRR, PH_RECV
	} phase_t;

	phase_t          phase_q, phase_d;
	logic            is_read_q, is_read_d;
	logic [3:0]      retry_q, retry_d;
	logic [LenW-1:0] idx_q, idx_d;
	logic [7:0]      taddr_q, taddr_d;
	logic [7:0]      treg_q, treg_d;
	logic [LenW-1:0] len_q, len_d;
	logic [2:0]      max_retries_q;
	bundle_t         bund_d;
	logic            in_acc;

	logic            do_finish, do_nack, pre;
	done_t           fin_ds;
	logic [LenW-1:0] idx_inc, len_sat;
	logic [3:0]      retry_inc;
	logic            retry_ok;
	logic [1:0]      pos;

	function automatic res_t cmd_res(cmd_t c, logic [7:0] sb);
		res_t r;
		r = '0;
		r.kind      = KIND_CMD;
		r.cmd       = c;
		r.send_byte = sb;
		return r;
	endfunction

	function automatic res_t done_res(done_t ds);
		res_t r;
		r = '0;
		r.kind = KIND_DONE;
		r.done = ds;
		return r;
	endfunction

	function automatic res_t data_res(logic [7:0] rx, logic [3:0] ri);
		res_t r;
		r = '0;
		r.kind       = KIND_DATA;
		r.read_byte  = rx;
		r.read_index = ri;
		return r;
	endfunction

	// Pick ack or nack for the next receive
	function automatic res_t recv_res(logic [LenW-1:0] i, logic [LenW-1:0] n);
		return cmd_res((LenW'(i + LenW'(1)) != n) ? CMD_RXACK : CMD_RXNACK, 8'h00);
	endfunction

	// Take a new item while the stage register is empty or moving on
	assign in_stall = bund_valid_s1 && !move;
	assign in_acc   = in_valid && !in_stall;

	assign idx_inc   = LenW'(idx_q + LenW'(1));
	assign retry_inc = 4'(retry_q + 4'd1);
	assign retry_ok  = retry_inc <= {1'b0, max_retries_q};
	assign len_sat   = (byte_count > LenW'(MaxLen)) ? LenW'(MaxLen) : byte_count;

	// Buffer access: loads write, every accepted item reads the byte a send may need
	always_comb begin
		buf_req.we    = in_acc && (req_type == REQ_LOAD);
		buf_req.waddr = load_index;
		buf_req.wdata = load_byte;
		buf_req.re    = in_acc;
		buf_req.raddr = (phase_q == PH_DATA) ? idx_inc[BufAw-1:0] : idx_q[BufAw-1:0];
	end

	// Decode the item against the current phase
	always_comb begin
		phase_d   = phase_q;
		is_read_d = is_read_q;
		retry_d   = retry_q;
		idx_d     = idx_q;
		taddr_d   = taddr_q;
		treg_d    = treg_q;
		len_d     = len_q;
		bund_d    = '0;
		do_finish = 1'b0;
		do_nack   = 1'b0;
		pre       = 1'b0;
		fin_ds    = DONE_BUSERR;

		case (req_type) inside
			REQ_WRITE, REQ_READ: begin
				if (phase_q == PH_IDLE) begin
					is_read_d     = (req_type == REQ_READ);
					taddr_d       = device_address;
					treg_d        = register_address;
					len_d         = len_sat;
					retry_d       = 4'd0;
					idx_d         = '0;
					bund_d.res[0] = cmd_res(CMD_START, 8'h00);
					bund_d.cnt    = 2'd1;
					phase_d       = PH_START;
				end
			end
			REQ_STATUS: begin
				unique case (phase_q)
					PH_IDLE: begin
					end
					PH_START: begin
						if (engine_status == ST_START) begin
							bund_d.res[0] = cmd_res(CMD_SEND, taddr_q & 8'hfe);
							bund_d.cnt    = 2'd1;
							phase_d       = PH_ADDRW;
						end else begin
							do_finish = 1'b1;
						end
					end
					PH_ADDRW: begin
						if (engine_status == ST_ADDRW_ACK) begin
							bund_d.res[0] = cmd_res(CMD_SEND, treg_q);
							bund_d.cnt    = 2'd1;
							phase_d       = PH_REG;
						end else if (engine_status == ST_ADDRW_NACK) begin
							do_nack = 1'b1;
						end else begin
							do_finish = 1'b1;
						end
					end
					PH_REG: begin
						if (engine_status == ST_TX_ACK) begin
							if (len_q == '0) begin
								do_finish = 1'b1;
								fin_ds    = DONE_OK;
							end else if (is_read_q) begin
								bund_d.res[0] = cmd_res(CMD_START, 8'h00);
								bund_d.cnt    = 2'd1;
								phase_d       = PH_RSTART;
							end else begin
								bund_d.res[0]         = cmd_res(CMD_SEND, 8'h00);
								bund_d.res[0].use_buf = 1'b1;
								bund_d.cnt            = 2'd1;
								phase_d               = PH_DATA;
							end
						end else if (engine_status == ST_TX_NACK) begin
							do_nack = 1'b1;
						end else begin
							do_finish = 1'b1;
						end
					end
					PH_DATA: begin
						if (engine_status == ST_TX_ACK) begin
							idx_d = idx_inc;
							if (idx_inc >= len_q) begin
								do_finish = 1'b1;
								fin_ds    = DONE_OK;
							end else begin
								bund_d.res[0]         = cmd_res(CMD_SEND, 8'h00);
								bund_d.res[0].use_buf = 1'b1;
								bund_d.cnt            = 2'd1;
							end
						end else if (engine_status == ST_TX_NACK) begin
							do_nack = 1'b1;
						end else begin
							do_finish = 1'b1;
						end
					end
					PH_RSTART: begin
						if (engine_status == ST_RSTART) begin
							bund_d.res[0] = cmd_res(CMD_SEND, taddr_q | 8'h01);
							bund_d.cnt    = 2'd1;
							phase_d       = PH_ADDRR;
						end else begin
							do_finish = 1'b1;
						end
					end
					PH_ADDRR: begin
						if (engine_status == ST_ADDRR_ACK) begin
							bund_d.res[0] = recv_res(idx_q, len_q);
							bund_d.cnt    = 2'd1;
							phase_d       = PH_RECV;
						end else if (engine_status == ST_ADDRR_NACK) begin
							do_nack = 1'b1;
						end else begin
							do_finish = 1'b1;
						end
					end
					PH_RECV: begin
						if (engine_status == ST_RX_ACK || engine_status == ST_RX_NACK) begin
							bund_d.res[0] = data_res(received_byte, idx_q[3:0]);
							pre           = 1'b1;
							idx_d         = idx_inc;
							if (engine_status == ST_RX_NACK || idx_inc >= len_q) begin
								do_finish = 1'b1;
								fin_ds    = DONE_OK;
							end else begin
								bund_d.res[1] = recv_res(idx_inc, len_q);
								bund_d.cnt    = 2'd2;
							end
						end else begin
							do_finish = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase

		// Append stop and the closing results after any leading result
		pos = pre ? 2'd1 : 2'd0;
		if (do_finish) begin
			bund_d.res[pos]       = cmd_res(CMD_STOP, 8'h00);
			bund_d.res[2'(pos+1)] = done_res(fin_ds);
			bund_d.cnt            = 2'(pos + 2'd2);
			phase_d               = PH_IDLE;
		end
		if (do_nack) begin
			bund_d.res[0] = cmd_res(CMD_STOP, 8'h00);
			bund_d.cnt    = 2'd2;
			retry_d       = retry_inc;
			if (retry_ok) begin
				bund_d.res[1] = cmd_res(CMD_START, 8'h00);
				idx_d         = '0;
				phase_d       = PH_START;
			end else begin
				bund_d.res[1] = done_res(DONE_FAILED);
				phase_d       = PH_IDLE;
			end
		end
	end

	// Hold transaction state and the stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			is_read_q     <= 1'b0;
			retry_q       <= 4'd0;
			idx_q         <= '0;
			taddr_q       <= 8'h00;
			treg_q        <= 8'h00;
			len_q         <= '0;
			max_retries_q <= 3'd3;
			bund_valid_s1 <= 1'b0;
			bund_s1       <= '0;
		end else begin
			if (cfg_write_en) begin
				max_retries_q <= cfg_write_data;
			end
			if (in_acc && req_type != REQ_LOAD) begin
				phase_q   <= phase_d;
				is_read_q <= is_read_d;
				retry_q   <= retry_d;
				idx_q     <= idx_d;
				taddr_q   <= taddr_d;
				treg_q    <= treg_d;
				len_q     <= len_d;
			end
			if (in_acc && bund_d.cnt != 2'd0) begin
				bund_valid_s1 <= 1'b1;
				bund_s1       <= bund_d;
			end else if (move) begin
				bund_valid_s1 <= 1'b0;
			end
		end
	end

endmodule

// ----- src/i2crts_out.sv -----
// ----------------------------------------------------------------------------
// i2crts_out
// Result serialiser: holds one item's result descriptors and hands them out
// one per cycle while out_stall is low, marking the final one.
// ----------------------------------------------------------------------------
module i2crts_out import i2crts_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    bund_valid_s1,
	input  bundle_t bund_in,
	output logic    move,
	output logic    out_valid,
	input  logic    out_stall,
	output res_t    cur,
	output logic    cur_last
);

	bundle_t    bund_q;
	logic [1:0] ptr_q;
	logic       valid_q;
	logic       take;

	assign out_valid = valid_q;
	assign cur       = bund_q.res[ptr_q];
	assign cur_last  = (ptr_q == 2'(bund_q.cnt - 2'd1));
	assign take      = valid_q && !out_stall;
	assign move      = bund_valid_s1 && (!valid_q || (take && cur_last));

	// Load a new set of results once the previous one is fully taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			ptr_q   <= 2'd0;
			bund_q  <= '0;
		end else begin
			if (move) begin
				valid_q <= 1'b1;
				ptr_q   <= 2'd0;
				bund_q  <= bund_in;
			end else if (take) begin
				if (cur_last) begin
					valid_q <= 1'b0;
				end else begin
					ptr_q <= 2'(ptr_q + 2'd1);
				end
			end
		end
	end

endmodule

// ----- src/i2c_register_transfer_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// i2c_register_transfer_sequencer_core
// Register read/write transaction sequencer above a byte-level I2C engine.
// ----------------------------------------------------------------------------
// The block takes one input item per cycle unless the input is stalled. An
// item that causes several results (at most three) holds the output while they
// leave one per cycle, as long as out_stall is low. The result stage register
// keeps one item's results while the previous item's results are still being
// taken, so the input is stalled only when both are full. Write data bytes are
// loaded into a 16-entry buffer memory; the byte a send command needs is read
// into a register when the status item is taken and joins its result as the
// result leaves the stage register. Engine status items that do not fit the
// phase of an active transaction end it with a stop and a bus error.
// ----------------------------------------------------------------------------
module i2c_register_transfer_sequencer_core import i2crts_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_write_en,
	input  logic [2:0] cfg_write_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] req_type,
	input  logic [7:0] device_address,
	input  logic [7:0] register_address,
	input  logic [4:0] byte_count,
	input  logic [3:0] load_index,
	input  logic [7:0] load_byte,
	input  logic [3:0] engine_status,
	input  logic [7:0] received_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] result_kind,
	output logic [2:0] engine_command,
	output logic [7:0] send_byte,
	output logic [7:0] read_byte,
	output logic [3:0] read_index,
	output logic [1:0] done_status,
	output logic       last
);

	bundle_t    bund_s1;
	bundle_t    bund_m;
	logic       bund_valid_s1;
	logic       move;
	buf_req_t   buf_req;
	logic [7:0] buf_rdata;
	res_t       cur;

	i2crts_ctrl u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write_en     (cfg_write_en),
		.cfg_write_data   (cfg_write_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.req_type         (req_type),
		.device_address   (device_address),
		.register_address (register_address),
		.byte_count       (byte_count),
		.load_index       (load_index),
		.load_byte        (load_byte),
		.engine_status    (engine_status),
		.received_byte    (received_byte),
		.move             (move),
		.bund_valid_s1    (bund_valid_s1),
		.bund_s1          (bund_s1),
		.buf_req          (buf_req)
	);

	i2crts_wbuf u_wbuf (
		.clk   (clk),
		.req   (buf_req),
		.rdata (buf_rdata)
	);

	// Drop the buffer byte into any send that asked for it
	always_comb begin
		bund_m = bund_s1;
		for (int k = 0; k < 3; k++) begin
			if (bund_s1.res[k].use_buf) begin
				bund_m.res[k].send_byte = buf_rdata;
			end
		end
	end

	i2crts_out u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.bund_valid_s1 (bund_valid_s1),
		.bund_in       (bund_m),
		.move          (move),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.cur           (cur),
		.cur_last      (last)
	);

	assign result_kind    = cur.kind;
	assign engine_command = cur.cmd;
	assign send_byte      = cur.send_byte;
	assign read_byte      = cur.read_byte;
	assign read_index     = cur.read_index;
	assign done_status    = cur.done;

	// A transaction done result is always the final result of its item
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_DONE |-> last)
		else $error("done result without last");

	// A held set of results carries one to three entries
	a_bund_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		bund_valid_s1 |-> bund_s1.cnt != 2'd0)
		else $error("empty result set in stage register");

	// Results handed to the serialiser show up at the output next cycle
	a_move_shows: assert property (@(posedge clk) disable iff (!arst_n)
		move |=> out_valid)
		else $error("moved results not presented");

	// The output empties after its final result is taken with nothing behind it
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last && !out_stall && !move |=> !out_valid)
		else $error("output valid after final result taken");

endmodule
